>>> rtl/core/srat_pkg.sv
// Package for the section range address translator.
// Holds table sizing, status and action codes, and the beat, entry and RAM request structs.
// No dependencies.
package srat_pkg;

   localparam int MAX_SECTIONS = 16;
   localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W        = 7;
   localparam int HIT_W        = 7;
   localparam int ENTRY_W      = 128;
   localparam int REQ_DATA_W   = 168;
   localparam int RSP_DATA_W   = 40;

   localparam logic [1:0] ST_MAPPED    = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_RAW    = 2'd2;

   localparam logic ACT_WRITE     = 1'b0;
   localparam logic ACT_TRANSLATE = 1'b1;

   typedef struct packed {
      logic [31:0] raw_pointer;
      logic [31:0] raw_size;
      logic [31:0] virt_size;
      logic [31:0] virt_start;
   } entry_type;

   typedef struct packed {
      logic              action;
      logic [CNT_W-1:0]  entry_index;
      entry_type         entry;
      logic [31:0]       query_address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       file_offset;
      logic [HIT_W-1:0]  hit_index;
   } res_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      entry_type         wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

endpackage

>>> rtl/core/srat_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module srat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/srat_ctrl.sv
// Scan sequencer: count register, table writes, one-entry-per-cycle range match.
// Depends on srat_pkg; drives the section table RAM through mem_req_type.
module srat_ctrl
   import srat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CNT_W-1:0]  csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req,
   output mem_req_type       mem_req,
   input  entry_type         mem_rdata,
   output logic              res_valid,
   output res_type           res,
   input  logic              out_free
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      addr_ff, addr_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] last_ff, last_in;
   res_type          res_ff, res_in;

   logic             accept;
   logic             accept_xlate;
   logic [CNT_W-1:0] limit;
   logic [31:0]      diff;
   logic [31:0]      span;
   logic             hit;
   logic             emit_go;

   assign limit = (count_ff > CNT_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS) : count_ff;

   assign emit_go      = (state_ff == S_EMIT) && out_free;
   assign req_ready    = (state_ff == S_IDLE) || emit_go;
   assign accept       = req_valid && req_ready;
   assign accept_xlate = accept && (req.action == ACT_TRANSLATE);

   // range check on the entry read last cycle
   assign diff = addr_ff - mem_rdata.virt_start;
   assign span = (mem_rdata.virt_size > mem_rdata.raw_size) ?
                 mem_rdata.virt_size : mem_rdata.raw_size;
   assign hit  = (addr_ff >= mem_rdata.virt_start) && (diff < span);

   always_comb begin
      mem_req.we    = accept && (req.action == ACT_WRITE) &&
                      (req.entry_index < CNT_W'(MAX_SECTIONS));
      mem_req.waddr = req.entry_index[IDX_W-1:0];
      mem_req.wdata = req.entry;
      mem_req.re    = accept_xlate ||
                      ((state_ff == S_SCAN) && !hit && (ptr_ff != last_ff));
      mem_req.raddr = (state_ff == S_SCAN) ? IDX_W'(ptr_ff + 1'b1) : '0;
   end

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      ptr_in   = ptr_ff;
      last_in  = last_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE, S_EMIT: begin
            if (state_ff == S_EMIT && out_free) begin
               state_in = S_IDLE;
            end
            if (accept_xlate) begin
               addr_in = req.query_address;
               ptr_in  = '0;
               last_in = IDX_W'(limit - 1'b1);
               if (limit == '0) begin
                  res_in.status      = ST_NOT_FOUND;
                  res_in.file_offset = '0;
                  res_in.hit_index   = '0;
                  state_in           = S_EMIT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               res_in.hit_index = HIT_W'(ptr_ff);
               if (mem_rdata.raw_pointer == '0) begin
                  res_in.status      = ST_NO_RAW;
                  res_in.file_offset = '0;
               end else begin
                  res_in.status      = ST_MAPPED;
                  res_in.file_offset = mem_rdata.raw_pointer + diff;
               end
               state_in = S_EMIT;
            end else if (ptr_ff == last_ff) begin
               res_in.status      = ST_NOT_FOUND;
               res_in.file_offset = '0;
               res_in.hit_index   = '0;
               state_in           = S_EMIT;
            end else begin
               ptr_in = IDX_W'(ptr_ff + 1'b1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      ptr_ff  <= ptr_in;
      last_ff <= last_in;
      res_ff  <= res_in;
   end

   assign res_valid = (state_ff == S_EMIT);
   assign res       = res_ff;

endmodule

>>> rtl/core/section_range_address_translate.sv
// Top level of the section range address translator: beat packing, output register.
// Depends on srat_pkg, srat_ctrl and srat_ram.
//
//   port group   dir  payload
//   req_*        in   tuser: action; tdata: entry/section fields, query address
//   rsp_*        out  tuser: status; tdata: file_offset, hit_index
//   csr_*        in   section_count write
//
// A write beat is written to the table as it is accepted. A translate beat reads
// one table entry per cycle from the section RAM port and stops at the first match
// or after min(count, MAX_SECTIONS) entries; the next beat can be taken in the
// same cycle that the result moves to the output register. Reset clears the count,
// sequencer and output valid; the table is not cleared. A held result stalls the
// sequencer only when the next result is ready before the output register drains.
module section_range_address_translate
   import srat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CNT_W-1:0]       csr_wdata,     // section_count
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,     // entry_index, virt_start, virt_size,
                                                 // raw_size, raw_pointer, query_address
   input  logic                   req_tuser,     // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,     // file_offset, hit_index
   output logic [1:0]             rsp_tuser      // status
);

   req_type     req;
   mem_req_type mem_req;
   entry_type   mem_rdata;
   logic [ENTRY_W-1:0] rd_bits;
   logic        res_valid;
   res_type     res;
   logic        out_free;
   logic        rsp_valid_ff;
   res_type     rsp_ff;

   always_comb begin
      req.action             = req_tuser;
      req.entry_index        = req_tdata[6:0];
      req.entry.virt_start   = req_tdata[38:7];
      req.entry.virt_size    = req_tdata[70:39];
      req.entry.raw_size     = req_tdata[102:71];
      req.entry.raw_pointer  = req_tdata[134:103];
      req.query_address      = req_tdata[166:135];
   end

   srat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free)
   );

   srat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SECTIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_en   (mem_req.re),
      .rd_addr (mem_req.raddr),
      .rd_data (rd_bits)
   );

   assign mem_rdata = entry_type'(rd_bits);

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {1'b0, rsp_ff.hit_index, rsp_ff.file_offset};

endmodule

>>> tb/section_range_address_translate_test.sv
// Self-checking bench for section_range_address_translate: fills the section table,
// sweeps section_count and checks each translate result against its own lookup.
// Depends on srat_pkg and the RTL of section_range_address_translate.
`timescale 1ns / 100ps

module section_range_address_translate_test;
   import srat_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CNT_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   section_range_address_translate dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // bench-side copy of the table, updated as write beats are accepted, and of the count
   entry_type section_copy [MAX_SECTIONS];
   int        active_count = 0;
   // table contents as planned by the stimulus, used only to aim addresses
   entry_type planned [MAX_SECTIONS];

   req_type   pending_reqs [$];
   res_type   lookups_due [$];
   int        mismatch_count = 0;
   bit        req_accepted = 1'b0;
   bit        steady = 1'b0;
   int        hold_requests = 0;
   int        hold_served = 0;
   int        hold_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // tdata, low bit up: entry_index, virt_start, virt_size, raw_size, raw_pointer,
   // query_address, one pad bit
   function automatic logic [REQ_DATA_W-1:0] pack_req(input req_type r);
      return {1'b0, r.query_address, r.entry.raw_pointer, r.entry.raw_size,
              r.entry.virt_size, r.entry.virt_start, r.entry_index};
   endfunction

   function automatic res_type lookup_section(input logic [31:0] addr);
      res_type     r;
      int          limit;
      logic [31:0] span;
      logic [31:0] rel;
      bit          found;
      r.status      = ST_NOT_FOUND;
      r.file_offset = '0;
      r.hit_index   = '0;
      found         = 1'b0;
      limit = (active_count > MAX_SECTIONS) ? MAX_SECTIONS : active_count;
      for (int i = 0; i < limit && !found; i++) begin
         span = (section_copy[i].virt_size > section_copy[i].raw_size) ?
                section_copy[i].virt_size : section_copy[i].raw_size;
         rel  = addr - section_copy[i].virt_start;
         if (addr >= section_copy[i].virt_start && rel < span) begin
            found       = 1'b1;
            r.hit_index = HIT_W'(i);
            if (section_copy[i].raw_pointer == '0) begin
               r.status = ST_NO_RAW;
            end else begin
               r.status      = ST_MAPPED;
               r.file_offset = section_copy[i].raw_pointer + rel;
            end
         end
      end
      return r;
   endfunction

   // sender
   always @(negedge clock) begin : drive_req
      req_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
            next_req = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= pack_req(next_req);
            req_tuser  <= next_req.action;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver; a long hold-off starts whenever hold_requests moves
   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = 300;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 27);
      end
   end

   // monitor: check results, then record accepted request beats
   always @(posedge clock) begin : watch
      res_type     want;
      logic [6:0]  slot;
      req_accepted = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (lookups_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, actual status %0d offset %h hit %0d",
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32]);
            end else begin
               want = lookups_due.pop_front();
               if (rsp_tuser !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_tuser);
               end
               if (rsp_tdata[31:0] !== want.file_offset) begin
                  mismatch_count++;
                  $display("%0t: file_offset mismatch, expected %h, actual %h",
                           $time, want.file_offset, rsp_tdata[31:0]);
               end
               if (rsp_tdata[38:32] !== want.hit_index) begin
                  mismatch_count++;
                  $display("%0t: hit_index mismatch, expected %0d, actual %0d",
                           $time, want.hit_index, rsp_tdata[38:32]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_accepted = 1'b1;
            if (req_tuser == ACT_WRITE) begin
               slot = req_tdata[6:0];
               if (slot < MAX_SECTIONS)
                  section_copy[slot[IDX_W-1:0]] = req_tdata[134:7];
            end else begin
               lookups_due.push_back(lookup_section(req_tdata[166:135]));
            end
         end
      end
   end

   task automatic add_write(input int idx, input logic [31:0] vstart, input logic [31:0] vsize,
                            input logic [31:0] rsize, input logic [31:0] rptr);
      req_type r;
      r.action           = ACT_WRITE;
      r.entry_index      = idx[CNT_W-1:0];
      r.entry.virt_start = vstart;
      r.entry.virt_size  = vsize;
      r.entry.raw_size   = rsize;
      r.entry.raw_pointer = rptr;
      r.query_address    = $urandom;
      if (idx < MAX_SECTIONS)
         planned[idx] = r.entry;
      pending_reqs.push_back(r);
   endtask

   task automatic add_translate(input logic [31:0] addr);
      req_type r;
      r.action            = ACT_TRANSLATE;
      r.entry_index       = CNT_W'($urandom_range(0, 95));
      r.entry.virt_start  = $urandom;
      r.entry.virt_size   = $urandom;
      r.entry.raw_size    = $urandom;
      r.entry.raw_pointer = $urandom;
      r.query_address     = addr;
      pending_reqs.push_back(r);
   endtask

   task automatic add_random_section(input int idx);
      logic [31:0] vstart;
      logic [31:0] vsize;
      logic [31:0] rsize;
      logic [31:0] rptr;
      int          kind;
      kind   = $urandom_range(0, 9);
      // most sections sit in one small window so they overlap and shadow each other
      vstart = (kind < 7) ? ($urandom & 32'h000F_FF00) : $urandom;
      vsize  = $urandom_range(0, 32'h3000);
      rsize  = $urandom_range(0, 32'h3000);
      if (kind == 0) begin
         vsize = '0;
         rsize = '0;
      end else if (kind == 1) begin
         vsize = $urandom;
      end else if (kind == 2) begin
         rsize = $urandom;
      end
      kind = $urandom_range(0, 19);
      rptr = (kind < 2) ? 32'h0 : (kind == 2) ? 32'hFFFF_FFF0 : $urandom;
      add_write(idx, vstart, vsize, rsize, rptr);
   endtask

   task automatic add_aimed_translate(input int count);
      int          i;
      logic [31:0] span;
      logic [31:0] vstart;
      logic [31:0] addr;
      i      = $urandom_range(0, ((count > MAX_SECTIONS) ? MAX_SECTIONS : (count == 0) ?
                                  MAX_SECTIONS : count) - 1);
      vstart = planned[i].virt_start;
      span   = (planned[i].virt_size > planned[i].raw_size) ?
               planned[i].virt_size : planned[i].raw_size;
      case ($urandom_range(0, 5))
         0: addr = vstart;
         1: addr = vstart + span - 1;
         2: addr = vstart + span;
         3: addr = vstart - 1;
         default: addr = (span == 0) ? vstart : vstart + ($urandom % span);
      endcase
      add_translate(addr);
   endtask

   task automatic add_random_items(input int n, input int count);
      int roll;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 22)
            add_random_section(($urandom_range(0, 9) < 8) ? $urandom_range(0, MAX_SECTIONS - 1) :
                               $urandom_range(MAX_SECTIONS, 95));
         else if (roll < 75)
            add_aimed_translate(count);
         else
            add_translate($urandom);
      end
   endtask

   // waits until no beat is queued, on the bus or owed a result
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() != 0 || req_tvalid || lookups_due.size() != 0);
   endtask

   task automatic set_section_count(input int value);
      wait_drained();
      // a trailing write beat can still be in flight
      repeat (24) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CNT_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      active_count = value;
   endtask

   initial begin : stimulus
      int counts [10];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, overlap priority, zero length, no raw data, wrap
      set_section_count(0);
      add_translate(32'hFFFF_FFFF);
      add_write(0, 32'h0000_1000, 32'h0000_0100, 32'h0000_0200, 32'h0000_0400);
      add_write(1, 32'h0000_1000, 32'h0000_1000, 32'h0000_0000, 32'h0000_8000);
      add_write(2, 32'h0000_3000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0005);
      add_write(3, 32'h0000_3000, 32'h0000_0010, 32'h0000_0000, 32'h0000_0000);
      add_write(4, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // slots past the table are dropped
      add_write(MAX_SECTIONS, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_write(95, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      set_section_count(5);
      add_translate(32'h0000_1000);
      add_translate(32'h0000_11FF);
      add_translate(32'h0000_1200);
      add_translate(32'h0000_1FFF);
      add_translate(32'h0000_2000);
      add_translate(32'h0000_3000);
      add_translate(32'h0000_3010);
      add_translate(32'hFFFF_FF00);
      add_translate(32'hFFFF_FFFF);
      add_translate(32'h0000_0FFF);
      add_translate(32'h0000_0000);

      // every slot gets written before any count can reach past slot 4
      for (int s = 0; s < MAX_SECTIONS; s++)
         add_random_section(s);

      counts = '{16, 96, 1, 15, 0, 17, 8, 63, $urandom_range(0, 96), 16};
      for (int p = 0; p < 10; p++) begin
         set_section_count(counts[p]);
         steady = (p == 0);
         if (p == 1)
            hold_requests++;
         add_random_items(131, counts[p]);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && lookups_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/srat_pkg.sv
rtl/core/srat_ram.sv
rtl/core/srat_ctrl.sv
rtl/core/section_range_address_translate.sv
tb/section_range_address_translate_test.sv
